FILE: sv/multi_channel_byte_fifo_bank_defines.svh
// assertion macros used by the byte fifo bank back end
`ifndef MULTI_CHANNEL_BYTE_FIFO_BANK_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_FIFO_BANK_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define MCFB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcfb assertion failed");

// condition holds in the cycle after the trigger
`define MCFB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcfb assertion failed");

`endif

FILE: sv/mcfb_pkg.sv
// types and constants shared by the byte fifo bank modules
`default_nettype none

package mcfb_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int RX_DEPTH     = 256;
    localparam int TX_DEPTH     = 4096;

    localparam int OP_W       = 3;
    localparam int CH_FIELD_W = 4;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int RX_LVL_W   = 9;
    localparam int TX_LVL_W   = 13;

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RX_PTR_W  = $clog2(RX_DEPTH);
    localparam int TX_PTR_W  = $clog2(TX_DEPTH);
    localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
    localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);
    localparam int RX_ADDR_W = $clog2(NUM_CHANNELS * RX_DEPTH);
    localparam int TX_ADDR_W = $clog2(NUM_CHANNELS * TX_DEPTH);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_RX    = 3'd0,
        OP_PUSH_TX    = 3'd1,
        OP_PULL_RX    = 3'd2,
        OP_PULL_TX    = 3'd3,
        OP_CLEAR_RX   = 3'd4,
        OP_CLEAR_TX   = 3'd5,
        OP_CLEAR_BOTH = 3'd6,
        OP_NONE       = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CHANNEL = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_UNDERFLOW   = 2'd3
    } status_t;

    // decoded command as it travels from front to back
    typedef struct packed {
        logic              bad_ch;
        logic [CH_W-1:0]   ch;
        logic              push_rx;
        logic              push_tx;
        logic              pull_rx;
        logic              pull_tx;
        logic              clr_rx;
        logic              clr_tx;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        status_t             status;
        logic                rx_empty;
        logic                rx_full;
        logic                tx_empty;
        logic                tx_full;
        logic [RX_LVL_W-1:0] rx_level;
        logic [TX_LVL_W-1:0] tx_level;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/mcfb_front.sv
// front end: takes command words and decodes them into queue entries
`default_nettype none

module mcfb_front (
    input  wire logic [mcfb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    output logic                                q_wr_valid,
    input  wire logic                           q_wr_ready,
    output mcfb_pkg::cmd_t                      q_wr_cmd
);
    import mcfb_pkg::*;

    op_t                   op_code;
    logic [CH_FIELD_W-1:0] channel;
    logic                  bad_ch;

    assign op_code = op_t'(s_tdata[OP_W-1:0]);
    assign channel = s_tdata[OP_W +: CH_FIELD_W];
    assign bad_ch  = ({1'b0, channel} >= (CH_FIELD_W + 1)'(NUM_CHANNELS));

    always_comb begin
        q_wr_cmd         = '0;
        q_wr_cmd.bad_ch  = bad_ch;
        q_wr_cmd.data    = s_tdata[OP_W + CH_FIELD_W +: BYTE_W];
        // an out-of-range channel never reaches the pointer file index
        q_wr_cmd.ch      = bad_ch ? '0 : channel[CH_W-1:0];
        unique case (op_code)
            OP_PUSH_RX: begin
                q_wr_cmd.push_rx = 1'b1;
            end
            OP_PUSH_TX: begin
                q_wr_cmd.push_tx = 1'b1;
            end
            OP_PULL_RX: begin
                q_wr_cmd.pull_rx = 1'b1;
            end
            OP_PULL_TX: begin
                q_wr_cmd.pull_tx = 1'b1;
            end
            OP_CLEAR_RX: begin
                q_wr_cmd.clr_rx = 1'b1;
            end
            OP_CLEAR_TX: begin
                q_wr_cmd.clr_tx = 1'b1;
            end
            OP_CLEAR_BOTH: begin
                q_wr_cmd.clr_rx = 1'b1;
                q_wr_cmd.clr_tx = 1'b1;
            end
            OP_NONE: begin
            end
        endcase
    end

    assign q_wr_valid = s_tvalid;
    assign s_tready   = q_wr_ready;

endmodule

`default_nettype wire

FILE: sv/mcfb_cmd_queue.sv
// short command queue between the decode front and the execute back
`default_nettype none

module mcfb_cmd_queue (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire mcfb_pkg::cmd_t wr_cmd,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output mcfb_pkg::cmd_t rd_cmd
);
    import mcfb_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CMDQ_IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_wr;
    logic                  do_rd;

    function automatic logic [CMDQ_IDX_W-1:0] idx_bump(input logic [CMDQ_IDX_W-1:0] idx);
        return (idx == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : CMDQ_IDX_W'(idx + 1'b1);
    endfunction

    assign wr_ready = (count_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_idx_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_idx_next = do_wr ? idx_bump(wr_idx_reg) : wr_idx_reg;
        rd_idx_next = do_rd ? idx_bump(rd_idx_reg) : rd_idx_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = CMDQ_CNT_W'(count_reg + 1'b1);
        end else if (do_rd && !do_wr) begin
            count_next = CMDQ_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_idx_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/mcfb_back.sv
// execute back end: pointer file, byte stores and result registers
`default_nettype none
`include "multi_channel_byte_fifo_bank_defines.svh"

module mcfb_back (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire mcfb_pkg::cmd_t q_cmd,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic [mcfb_pkg::M_TDATA_W-1:0] m_tdata
);
    import mcfb_pkg::*;

    // per channel pointers and fill counts
    logic [RX_PTR_W-1:0]  rx_wp_reg   [NUM_CHANNELS];
    logic [RX_PTR_W-1:0]  rx_rp_reg   [NUM_CHANNELS];
    logic [RX_FILL_W-1:0] rx_fill_reg [NUM_CHANNELS];
    logic [TX_PTR_W-1:0]  tx_wp_reg   [NUM_CHANNELS];
    logic [TX_PTR_W-1:0]  tx_rp_reg   [NUM_CHANNELS];
    logic [TX_FILL_W-1:0] tx_fill_reg [NUM_CHANNELS];

    logic [BYTE_W-1:0] rx_store_mem [NUM_CHANNELS * RX_DEPTH];
    logic [BYTE_W-1:0] tx_store_mem [NUM_CHANNELS * TX_DEPTH];
    logic [BYTE_W-1:0] rx_rdata_reg;
    logic [BYTE_W-1:0] tx_rdata_reg;

    logic    s1_valid_reg, s1_valid_next;
    result_t s1_res_reg;
    logic    s1_pull_rx_reg;
    logic    s1_pull_tx_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic exec_fire;
    logic s1_ready;
    logic out_ready;
    logic s1_move;

    logic [CH_W-1:0]      ch;
    logic [RX_PTR_W-1:0]  cur_rx_wp, cur_rx_rp, nxt_rx_wp, nxt_rx_rp;
    logic [TX_PTR_W-1:0]  cur_tx_wp, cur_tx_rp, nxt_tx_wp, nxt_tx_rp;
    logic [RX_FILL_W-1:0] cur_rx_fill, nxt_rx_fill;
    logic [TX_FILL_W-1:0] cur_tx_fill, nxt_tx_fill;
    logic                 rx_room, tx_room;
    logic                 do_push_rx, do_push_tx, do_pull_rx, do_pull_tx;
    logic                 overflow, underflow;
    logic [RX_ADDR_W-1:0] rx_waddr, rx_raddr;
    logic [TX_ADDR_W-1:0] tx_waddr, tx_raddr;
    result_t              res;

    function automatic logic [RX_PTR_W-1:0] rx_bump(input logic [RX_PTR_W-1:0] ptr);
        return (ptr == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : RX_PTR_W'(ptr + 1'b1);
    endfunction

    function automatic logic [TX_PTR_W-1:0] tx_bump(input logic [TX_PTR_W-1:0] ptr);
        return (ptr == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : TX_PTR_W'(ptr + 1'b1);
    endfunction

    assign out_ready = !out_valid_reg || m_tready;
    assign s1_move   = s1_valid_reg && out_ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_ready   = s1_ready;
    assign exec_fire = q_valid && s1_ready;

    assign ch          = q_cmd.ch;
    assign cur_rx_wp   = rx_wp_reg[ch];
    assign cur_rx_rp   = rx_rp_reg[ch];
    assign cur_rx_fill = rx_fill_reg[ch];
    assign cur_tx_wp   = tx_wp_reg[ch];
    assign cur_tx_rp   = tx_rp_reg[ch];
    assign cur_tx_fill = tx_fill_reg[ch];

    assign rx_room = (cur_rx_fill < RX_FILL_W'(RX_DEPTH));
    assign tx_room = (cur_tx_fill < TX_FILL_W'(TX_DEPTH));

    assign do_push_rx = q_cmd.push_rx && !q_cmd.bad_ch && rx_room;
    assign do_push_tx = q_cmd.push_tx && !q_cmd.bad_ch && tx_room;
    assign do_pull_rx = q_cmd.pull_rx && !q_cmd.bad_ch && (cur_rx_fill != '0);
    assign do_pull_tx = q_cmd.pull_tx && !q_cmd.bad_ch && (cur_tx_fill != '0);
    assign overflow   = (q_cmd.push_rx && !rx_room) || (q_cmd.push_tx && !tx_room);
    assign underflow  = (q_cmd.pull_rx && (cur_rx_fill == '0))
                     || (q_cmd.pull_tx && (cur_tx_fill == '0));

    // channel base plus pointer
    assign rx_waddr = RX_ADDR_W'(ch) * RX_ADDR_W'(RX_DEPTH) + RX_ADDR_W'(cur_rx_wp);
    assign rx_raddr = RX_ADDR_W'(ch) * RX_ADDR_W'(RX_DEPTH) + RX_ADDR_W'(cur_rx_rp);
    assign tx_waddr = TX_ADDR_W'(ch) * TX_ADDR_W'(TX_DEPTH) + TX_ADDR_W'(cur_tx_wp);
    assign tx_raddr = TX_ADDR_W'(ch) * TX_ADDR_W'(TX_DEPTH) + TX_ADDR_W'(cur_tx_rp);

    always_comb begin
        nxt_rx_wp   = do_push_rx ? rx_bump(cur_rx_wp) : cur_rx_wp;
        nxt_rx_rp   = do_pull_rx ? rx_bump(cur_rx_rp) : cur_rx_rp;
        nxt_tx_wp   = do_push_tx ? tx_bump(cur_tx_wp) : cur_tx_wp;
        nxt_tx_rp   = do_pull_tx ? tx_bump(cur_tx_rp) : cur_tx_rp;
        nxt_rx_fill = cur_rx_fill;
        nxt_tx_fill = cur_tx_fill;
        if (do_push_rx) begin
            nxt_rx_fill = RX_FILL_W'(cur_rx_fill + 1'b1);
        end else if (do_pull_rx) begin
            nxt_rx_fill = RX_FILL_W'(cur_rx_fill - 1'b1);
        end
        if (do_push_tx) begin
            nxt_tx_fill = TX_FILL_W'(cur_tx_fill + 1'b1);
        end else if (do_pull_tx) begin
            nxt_tx_fill = TX_FILL_W'(cur_tx_fill - 1'b1);
        end
        if (q_cmd.clr_rx) begin
            nxt_rx_wp   = '0;
            nxt_rx_rp   = '0;
            nxt_rx_fill = '0;
        end
        if (q_cmd.clr_tx) begin
            nxt_tx_wp   = '0;
            nxt_tx_rp   = '0;
            nxt_tx_fill = '0;
        end
    end

    always_comb begin
        if (q_cmd.bad_ch) begin
            res.status   = ST_BAD_CHANNEL;
            res.rx_empty = 1'b1;
            res.rx_full  = 1'b1;
            res.tx_empty = 1'b1;
            res.tx_full  = 1'b1;
            res.rx_level = '0;
            res.tx_level = '0;
        end else begin
            priority if (overflow) begin
                res.status = ST_OVERFLOW;
            end else if (underflow) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.status = ST_OK;
            end
            res.rx_empty = (nxt_rx_fill == '0);
            res.rx_full  = (nxt_rx_fill >= RX_FILL_W'(RX_DEPTH));
            res.tx_empty = (nxt_tx_fill == '0);
            res.tx_full  = (nxt_tx_fill >= TX_FILL_W'(TX_DEPTH));
            res.rx_level = RX_LVL_W'(nxt_rx_fill);
            res.tx_level = TX_LVL_W'(nxt_tx_fill);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                rx_wp_reg[i]   <= '0;
                rx_rp_reg[i]   <= '0;
                rx_fill_reg[i] <= '0;
                tx_wp_reg[i]   <= '0;
                tx_rp_reg[i]   <= '0;
                tx_fill_reg[i] <= '0;
            end
        end else if (exec_fire && !q_cmd.bad_ch) begin
            rx_wp_reg[ch]   <= nxt_rx_wp;
            rx_rp_reg[ch]   <= nxt_rx_rp;
            rx_fill_reg[ch] <= nxt_rx_fill;
            tx_wp_reg[ch]   <= nxt_tx_wp;
            tx_rp_reg[ch]   <= nxt_tx_rp;
            tx_fill_reg[ch] <= nxt_tx_fill;
        end
    end

    // byte stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (exec_fire && do_push_rx) begin
            rx_store_mem[rx_waddr] <= q_cmd.data;
        end
        if (exec_fire && do_pull_rx) begin
            rx_rdata_reg <= rx_store_mem[rx_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire && do_push_tx) begin
            tx_store_mem[tx_waddr] <= q_cmd.data;
        end
        if (exec_fire && do_pull_tx) begin
            tx_rdata_reg <= tx_store_mem[tx_raddr];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (exec_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            s1_res_reg     <= res;
            s1_pull_rx_reg <= do_pull_rx;
            s1_pull_tx_reg <= do_pull_tx;
        end
        if (s1_move) begin
            out_res_reg <= s1_res_reg;
            // read data comes from the store read register, loaded when the pull executes
            priority if (s1_pull_rx_reg) begin
                out_data_reg <= rx_rdata_reg;
            end else if (s1_pull_tx_reg) begin
                out_data_reg <= tx_rdata_reg;
            end else begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (M_TDATA_W - BYTE_W - STATUS_W - 4 - RX_LVL_W - TX_LVL_W)'(0),
        out_res_reg.tx_level,
        out_res_reg.rx_level,
        out_res_reg.tx_full,
        out_res_reg.tx_empty,
        out_res_reg.rx_full,
        out_res_reg.rx_empty,
        out_res_reg.status,
        out_data_reg
    };

    `MCFB_ASSERT_IMP(a_rx_fill_bound, aclk, aresetn, q_valid && !q_cmd.bad_ch, cur_rx_fill <= RX_FILL_W'(RX_DEPTH))
    `MCFB_ASSERT_IMP(a_tx_fill_bound, aclk, aresetn, q_valid && !q_cmd.bad_ch, cur_tx_fill <= TX_FILL_W'(TX_DEPTH))
    `MCFB_ASSERT_NEXT(a_s1_holds, aclk, aresetn, s1_valid_reg && !out_ready, s1_valid_reg)
    `MCFB_ASSERT_NEXT(a_bad_ch_status, aclk, aresetn, exec_fire && q_cmd.bad_ch, s1_res_reg.status == ST_BAD_CHANNEL)
    `MCFB_ASSERT_IMP(a_pull_ok, aclk, aresetn, s1_valid_reg && (s1_pull_rx_reg || s1_pull_tx_reg), (s1_res_reg.status == ST_OK) && !(s1_pull_rx_reg && s1_pull_tx_reg))

endmodule

`default_nettype wire

FILE: sv/multi_channel_byte_fifo_bank.sv
// Multi-channel byte fifo bank, top level.
// Each of the eight channels owns an rx byte queue (256 deep) and a tx byte
// queue (4096 deep). A command word on the s_ channel names an op, a channel
// and a data byte; every command returns exactly one result word on the m_
// channel with the pulled byte, a status code, the channel's empty and full
// flags and both fill levels after the command.
// Status: ok, bad channel (nothing changes, flags all set, levels zero),
// overflow (push to a full queue is dropped), underflow (pull from an empty
// queue returns zero).
// A word accepted on s_ passes the command queue, the s1 registers and the
// output register before it shows on m_tvalid. Throughput: one word per cycle
// while m_tready keeps up; each command does one read-modify-write of the
// channel's pointer and fill registers plus one store access as it executes,
// and the registered store read adds one stage ahead of the output register.
// A two-entry command queue sits between decode and execute, so s_tready
// stays high while results wait. When the receiver holds m_tready low the
// output register, the read stage and then the command queue fill up, after
// which s_tready drops. Reset clears all pointers and fill counts at once;
// store contents are undefined but never read before written.
`default_nettype none

module multi_channel_byte_fifo_bank (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // op[2:0], channel[6:3], data_in[14:7], zero pad
    input  wire logic [mcfb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // data_out[7:0], status[9:8], rx_empty[10], rx_full[11], tx_empty[12],
    // tx_full[13], rx_level[22:14], tx_level[35:23], zero pad
    output logic [mcfb_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import mcfb_pkg::*;

    logic q_wr_valid;
    logic q_wr_ready;
    cmd_t q_wr_cmd;
    logic q_rd_valid;
    logic q_rd_ready;
    cmd_t q_rd_cmd;

    mcfb_front u_front (
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_cmd   (q_wr_cmd)
    );

    mcfb_cmd_queue u_cmd_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_cmd   (q_wr_cmd),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_cmd   (q_rd_cmd)
    );

    mcfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_rd_valid),
        .q_ready  (q_rd_ready),
        .q_cmd    (q_rd_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: verif/mcfb_bank_checker.sv
// checker for the byte fifo bank: rebuilds every queue and matches each result word
`default_nettype none

module mcfb_bank_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [mcfb_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [mcfb_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    output int                                  words_in,
    output int                                  words_out,
    output int                                  mismatches
);
    import mcfb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_out;
        status_t             status;
        logic                rx_empty;
        logic                rx_full;
        logic                tx_empty;
        logic                tx_full;
        logic [RX_LVL_W-1:0] rx_level;
        logic [TX_LVL_W-1:0] tx_level;
    } fifo_report_t;

    fifo_report_t pending_reports[$];

    logic [BYTE_W-1:0]    rx_mem [NUM_CHANNELS][RX_DEPTH];
    logic [BYTE_W-1:0]    tx_mem [NUM_CHANNELS][TX_DEPTH];
    logic [RX_PTR_W-1:0]  rx_wr  [NUM_CHANNELS];
    logic [RX_PTR_W-1:0]  rx_rd  [NUM_CHANNELS];
    logic [RX_FILL_W-1:0] rx_cnt [NUM_CHANNELS];
    logic [TX_PTR_W-1:0]  tx_wr  [NUM_CHANNELS];
    logic [TX_PTR_W-1:0]  tx_rd  [NUM_CHANNELS];
    logic [TX_FILL_W-1:0] tx_cnt [NUM_CHANNELS];

    // applies one command to the mirrored queues and returns the report it should give
    function automatic fifo_report_t run_command(input op_t op,
                                                 input logic [CH_FIELD_W-1:0] chan,
                                                 input logic [BYTE_W-1:0] din);
        fifo_report_t rep;
        int c;
        rep = '0;
        rep.status = ST_OK;
        if (chan >= NUM_CHANNELS) begin
            rep.status   = ST_BAD_CHANNEL;
            rep.rx_empty = 1'b1;
            rep.rx_full  = 1'b1;
            rep.tx_empty = 1'b1;
            rep.tx_full  = 1'b1;
            return rep;
        end
        c = int'(chan);
        case (op)
            OP_PUSH_RX: begin
                if (rx_cnt[c] < RX_DEPTH) begin
                    rx_mem[c][rx_wr[c]] = din;
                    rx_wr[c]  = (rx_wr[c] == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_wr[c] + 1'b1;
                    rx_cnt[c] = rx_cnt[c] + 1'b1;
                end else begin
                    rep.status = ST_OVERFLOW;
                end
            end
            OP_PUSH_TX: begin
                if (tx_cnt[c] < TX_DEPTH) begin
                    tx_mem[c][tx_wr[c]] = din;
                    tx_wr[c]  = (tx_wr[c] == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_wr[c] + 1'b1;
                    tx_cnt[c] = tx_cnt[c] + 1'b1;
                end else begin
                    rep.status = ST_OVERFLOW;
                end
            end
            OP_PULL_RX: begin
                if (rx_cnt[c] != 0) begin
                    rep.data_out = rx_mem[c][rx_rd[c]];
                    rx_rd[c]  = (rx_rd[c] == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_rd[c] + 1'b1;
                    rx_cnt[c] = rx_cnt[c] - 1'b1;
                end else begin
                    rep.status = ST_UNDERFLOW;
                end
            end
            OP_PULL_TX: begin
                if (tx_cnt[c] != 0) begin
                    rep.data_out = tx_mem[c][tx_rd[c]];
                    tx_rd[c]  = (tx_rd[c] == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_rd[c] + 1'b1;
                    tx_cnt[c] = tx_cnt[c] - 1'b1;
                end else begin
                    rep.status = ST_UNDERFLOW;
                end
            end
            OP_CLEAR_RX, OP_CLEAR_TX, OP_CLEAR_BOTH: begin
                if (op != OP_CLEAR_TX) begin
                    rx_wr[c]  = '0;
                    rx_rd[c]  = '0;
                    rx_cnt[c] = '0;
                end
                if (op != OP_CLEAR_RX) begin
                    tx_wr[c]  = '0;
                    tx_rd[c]  = '0;
                    tx_cnt[c] = '0;
                end
            end
            default: ;
        endcase
        rep.rx_empty = (rx_cnt[c] == 0);
        rep.rx_full  = (rx_cnt[c] >= RX_DEPTH);
        rep.tx_empty = (tx_cnt[c] == 0);
        rep.tx_full  = (tx_cnt[c] >= TX_DEPTH);
        rep.rx_level = RX_LVL_W'(rx_cnt[c]);
        rep.tx_level = TX_LVL_W'(tx_cnt[c]);
        return rep;
    endfunction

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout int bad);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad++;
        end
    endtask

    always @(posedge aclk) begin
        fifo_report_t want;
        int bad;
        if (!aresetn) begin
            foreach (rx_cnt[i]) begin
                rx_wr[i]  = '0;
                rx_rd[i]  = '0;
                rx_cnt[i] = '0;
                tx_wr[i]  = '0;
                tx_rd[i]  = '0;
                tx_cnt[i] = '0;
            end
            pending_reports.delete();
            words_in   <= 0;
            words_out  <= 0;
            mismatches <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_reports.push_back(run_command(op_t'(s_tdata[2:0]), s_tdata[6:3],
                                                      s_tdata[14:7]));
                words_in <= words_in + 1;
            end
            if (m_tvalid && m_tready) begin
                bad = 0;
                if (pending_reports.size() == 0) begin
                    $error("result word with no command waiting: %h", m_tdata);
                    bad = 1;
                end else begin
                    want = pending_reports.pop_front();
                    match_field("data_out", 32'(want.data_out), 32'(m_tdata[7:0]), bad);
                    match_field("status", 32'(want.status), 32'(m_tdata[9:8]), bad);
                    match_field("rx_empty", 32'(want.rx_empty), 32'(m_tdata[10]), bad);
                    match_field("rx_full", 32'(want.rx_full), 32'(m_tdata[11]), bad);
                    match_field("tx_empty", 32'(want.tx_empty), 32'(m_tdata[12]), bad);
                    match_field("tx_full", 32'(want.tx_full), 32'(m_tdata[13]), bad);
                    match_field("rx_level", 32'(want.rx_level), 32'(m_tdata[22:14]), bad);
                    match_field("tx_level", 32'(want.tx_level), 32'(m_tdata[35:23]), bad);
                end
                words_out  <= words_out + 1;
                mismatches <= mismatches + bad;
            end
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_multi_channel_byte_fifo_bank.sv
// testbench top for the byte fifo bank: drives commands, paces results, gives the verdict
`default_nettype none

module tb_multi_channel_byte_fifo_bank;
    import mcfb_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 8;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;

    int words_in;
    int words_out;
    int mismatches;
    int items_sent = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    bit steady     = 1'b0;

    multi_channel_byte_fifo_bank DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    mcfb_bank_checker bank_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .words_in   (words_in),
        .words_out  (words_out),
        .mismatches (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic issue_command(input op_t op, input int chan, input int din);
        while (!steady && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= S_TDATA_W'({BYTE_W'(din), CH_FIELD_W'(chan), op});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic issue_burst(input op_t op, input int chan, input int count);
        repeat (count) issue_command(op, chan, $urandom_range(255));
    endtask

    // stop offering words until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_in != words_out);
    endtask

    function automatic op_t random_op();
        int r;
        r = $urandom_range(99);
        if (r < 30) return OP_PUSH_RX;
        else if (r < 55) return OP_PUSH_TX;
        else if (r < 72) return OP_PULL_RX;
        else if (r < 89) return OP_PULL_TX;
        else if (r < 96) return op_t'($urandom_range(4, 6));
        else return OP_NONE;
    endfunction

    initial begin
        int rx_ch;
        int tx_ch;
        int chan;
        int r;
        int len;
        int start;
        bit held;
        bit paused;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue_command(OP_NONE, 0, 'h00);
        issue_command(OP_PULL_RX, 0, 'hFF);
        issue_command(OP_PULL_TX, 0, 'h00);
        issue_command(OP_PUSH_RX, 0, 'h00);
        issue_command(OP_PUSH_RX, 7, 'hFF);
        issue_command(OP_PUSH_TX, 0, 'hA5);
        issue_command(OP_PUSH_TX, 7, 'h5A);
        issue_command(OP_PULL_RX, 0, 'h00);
        issue_command(OP_PULL_TX, 7, 'h00);
        // channel numbers past the bank
        issue_command(OP_PUSH_RX, 8, 'hFF);
        issue_command(OP_PULL_TX, 15, 'h00);
        issue_command(OP_CLEAR_BOTH, 12, 'hFF);
        issue_command(OP_NONE, 15, 'h00);
        issue_command(OP_PUSH_RX, 3, 'h3C);
        issue_command(OP_PUSH_TX, 3, 'hC3);
        issue_command(OP_CLEAR_BOTH, 3, 'h00);
        issue_command(OP_PULL_RX, 3, 'h00);
        issue_command(OP_PULL_TX, 3, 'h00);
        issue_command(OP_CLEAR_RX, 7, 'h00);
        issue_command(OP_PULL_RX, 7, 'h00);
        issue_command(OP_CLEAR_TX, 0, 'h00);
        issue_command(OP_NONE, 7, 'hFF);
        wait_drained();

        // fill rx to overflow, wrap both pointers, drain to underflow
        rx_ch = $urandom_range(NUM_CHANNELS - 1);
        issue_command(OP_CLEAR_BOTH, rx_ch, $urandom_range(255));
        steady = 1'b1;
        issue_burst(OP_PUSH_RX, rx_ch, RX_DEPTH + 2);
        issue_burst(OP_PULL_RX, rx_ch, 40);
        issue_burst(OP_PUSH_RX, rx_ch, 40);
        steady = 1'b0;
        issue_burst(OP_PULL_RX, rx_ch, RX_DEPTH + 4);

        tx_ch = $urandom_range(NUM_CHANNELS - 1);
        issue_command(OP_CLEAR_BOTH, tx_ch, $urandom_range(255));
        issue_burst(OP_PUSH_TX, tx_ch, 40);
        issue_burst(OP_PULL_TX, tx_ch, 44);
        wait_drained();

        start  = items_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (!held && items_sent - start > 80) begin
                held = 1'b1;
                hold_req++;
            end
            if (!paused && items_sent - start > 170) begin
                paused = 1'b1;
                wait_drained();
            end
            r    = $urandom_range(99);
            chan = $urandom_range(NUM_CHANNELS - 1);
            if (r < 40) begin
                len = $urandom_range(1, 16);
                repeat (len) begin
                    if ($urandom_range(99) < 6)
                        issue_command(random_op(), $urandom_range(NUM_CHANNELS, 15),
                                      $urandom_range(255));
                    else
                        issue_command(random_op(), chan, $urandom_range(255));
                end
            end else if (r < 55) begin
                issue_burst(OP_PUSH_RX, chan, $urandom_range(1, 40));
            end else if (r < 65) begin
                issue_burst(OP_PUSH_TX, chan, $urandom_range(1, 40));
            end else if (r < 80) begin
                issue_burst($urandom_range(1) ? OP_PULL_RX : OP_PULL_TX, chan,
                            $urandom_range(1, 40));
            end else if (r < 88) begin
                issue_command(op_t'($urandom_range(4, 6)), chan, $urandom_range(255));
            end else if (r < 95) begin
                len = $urandom_range(1, 4);
                repeat (len)
                    issue_command(op_t'($urandom_range(7)), $urandom_range(NUM_CHANNELS, 15),
                                  $urandom_range(255));
            end else begin
                issue_command(OP_NONE, $urandom_range(15), $urandom_range(255));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && words_in == words_out)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
